### rtl/core/dppm_pkg.sv
// ----------------------------------------------------------------------------
// dppm_pkg
// Shared constants, codes, control structures and helpers for the dial-plan
// prefix matcher.
// ----------------------------------------------------------------------------
package dppm_pkg;

  // Default sizing of the trie.
  localparam int NODE_COUNT_DEF    = 256;
  localparam int PREFIX_DIGITS_DEF = 10;

  // Digit code layout of one item.
  localparam int CODE_W         = 4;
  localparam int CODE_SLOTS     = 11;
  localparam int CODES_W        = CODE_SLOTS * CODE_W;
  localparam int LINKS_PER_NODE = 12;
  localparam int LEN_W          = 8;
  localparam int COUNT_W        = 8;
  localparam int NODES_W        = 9;

  localparam logic [CODE_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [CODE_W-1:0] CODE_HASH = 4'd11;
  localparam logic [CODE_W-1:0] CODE_NONE = 4'd15;

  // Commands carried in the input tuser.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  // Result status codes carried in the output tuser.
  localparam logic [2:0] ST_MORE     = 3'd0;
  localparam logic [2:0] ST_COMPLETE = 3'd1;
  localparam logic [2:0] ST_VALID    = 3'd2;
  localparam logic [2:0] ST_WRONG    = 3'd3;
  localparam logic [2:0] ST_STORED   = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the accepted item and read the root row
    logic step;      // evaluate one trie level
    logic clr_step;  // write one zero row of the clearing pass
    logic clr_end;   // close the clearing pass
    logic emit;      // move the finished result into the output register
  } dppm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_req; // the captured item is a clear
    logic finished;  // the current step produces the result
    logic clr_last;  // the clearing pass is at its last row
    logic out_free;  // the output register can take a result this cycle
  } dppm_sts_t;

  // Digit code at a position; positions past the last slot read as none.
  function automatic logic [CODE_W-1:0] code_at(input logic [CODES_W-1:0] codes,
                                                input logic [4:0] pos);
    logic [CODE_W-1:0] c;
    if (pos >= 5'(CODE_SLOTS)) begin
      c = CODE_NONE;
    end else begin
      c = codes[CODE_W*pos +: CODE_W];
    end
    return c;
  endfunction

endpackage

### rtl/core/dppm_ctrl.sv
// ----------------------------------------------------------------------------
// dppm_ctrl
// Sequencing state machine: clearing pass, item capture, trie walk and
// result hand-off.
// ----------------------------------------------------------------------------
module dppm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  dppm_pkg::dppm_sts_t sts,
  output dppm_pkg::dppm_cmd_t cmd
);

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_STEP = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       reply_r, reply_nxt;

  always_comb begin
    state_nxt = state_r;
    reply_nxt = reply_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (sts.clear_req) begin
          reply_nxt = 1'b1;
          state_nxt = S_CLR;
        end else begin
          cmd.step = 1'b1;
          if (sts.finished) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          cmd.clr_end = 1'b1;
          reply_nxt   = 1'b0;
          state_nxt   = reply_r ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Reset starts a clearing pass that gives no result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      reply_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      reply_r <= reply_nxt;
    end
  end

endmodule

### rtl/core/dppm_datapath.sv
// ----------------------------------------------------------------------------
// dppm_datapath
// Trie row memory, walk registers, node allocator and output register.
// ----------------------------------------------------------------------------
module dppm_datapath #(
  parameter int NODE_COUNT    = dppm_pkg::NODE_COUNT_DEF,
  parameter int PREFIX_DIGITS = dppm_pkg::PREFIX_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dppm_pkg::dppm_cmd_t cmd,
  output dppm_pkg::dppm_sts_t sts,
  input  logic [1:0]          in_tuser,
  input  logic [63:0]         in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [2:0]          out_tuser,
  output logic [23:0]         out_tdata
);

  localparam int NW     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int CW     = $clog2(NODE_COUNT + 1);
  localparam int IW     = $clog2(PREFIX_DIGITS + 1);
  localparam int LW     = dppm_pkg::LINKS_PER_NODE * NW;
  localparam int TERM_B = LW;
  localparam int RW     = LW + 1 + dppm_pkg::COUNT_W;

  // One row per node: child links, terminal flag and remaining count.
  logic [RW-1:0] mem [NODE_COUNT];
  logic [RW-1:0] rd_data_r;

  logic [1:0]                        cmd_r;
  logic [dppm_pkg::CODES_W-1:0]      codes_r;
  logic [dppm_pkg::LEN_W-1:0]        dlen_r, nlen_r;
  logic [IW-1:0]                     idx_r;
  logic [NW-1:0]                     node_r;
  logic [CW-1:0]                     nfree_r;
  logic                              full_r;
  logic [NW-1:0]                     clr_addr_r;
  logic [2:0]                        res_status_r;
  logic [dppm_pkg::LEN_W-1:0]        res_wanted_r;
  logic                              out_valid_r;
  logic [2:0]                        out_status_r;
  logic [dppm_pkg::LEN_W-1:0]        out_wanted_r;
  logic [dppm_pkg::NODES_W-1:0]      out_nodes_r;

  logic                              rd_en, wr_en;
  logic [NW-1:0]                     rd_addr, wr_addr, next_node;
  logic [RW-1:0]                     wr_data, row_linked;
  logic                              finish, advance, alloc, set_full;
  logic [2:0]                        fin_status;
  logic [dppm_pkg::LEN_W-1:0]        fin_wanted, left, wanted;
  logic [IW-1:0]                     limit;
  logic [dppm_pkg::CODE_W-1:0]       code_cur, lk_sel;
  logic [NW-1:0]                     link;
  logic                              term;
  logic [dppm_pkg::COUNT_W-1:0]      cnt, remain;
  logic                              in_range, look_cont;
  logic [CW+dppm_pkg::NODES_W-1:0]   nodes_wide;

  always_comb begin
    limit    = (dlen_r > dppm_pkg::LEN_W'(PREFIX_DIGITS)) ? IW'(PREFIX_DIGITS)
                                                         : dlen_r[IW-1:0];
    code_cur = dppm_pkg::code_at(codes_r, 5'(idx_r));
    lk_sel   = (code_cur <= dppm_pkg::CODE_HASH) ? code_cur : '0;
    link     = rd_data_r[lk_sel*NW +: NW];
    term     = rd_data_r[TERM_B];
    cnt      = rd_data_r[RW-1 -: dppm_pkg::COUNT_W];
    in_range = idx_r < limit;
    // A longer prefix continues when the next dialed code has a child here.
    look_cont = (dppm_pkg::LEN_W'(idx_r) < dlen_r)
                && (5'(idx_r) < 5'(dppm_pkg::CODE_SLOTS))
                && (code_cur <= dppm_pkg::CODE_HASH) && (link != '0);
    left     = dlen_r - dppm_pkg::LEN_W'(idx_r);
    wanted   = (left >= cnt) ? '0 : cnt - left;
    remain   = (nlen_r > dppm_pkg::LEN_W'(idx_r)) ? nlen_r - dppm_pkg::LEN_W'(idx_r) : '0;
    row_linked = rd_data_r;
    row_linked[lk_sel*NW +: NW] = NW'(nfree_r);
  end

  // Step decision for the current trie level.
  always_comb begin
    finish     = 1'b0;
    fin_status = dppm_pkg::ST_WRONG;
    fin_wanted = '0;
    advance    = 1'b0;
    alloc      = 1'b0;
    set_full   = 1'b0;
    next_node  = link;
    rd_en      = 1'b0;
    rd_addr    = link;
    wr_en      = 1'b0;
    wr_addr    = node_r;
    wr_data    = row_linked;
    case (cmd_r)
      dppm_pkg::CMD_LOOKUP: begin
        if (term && (idx_r != '0) && !look_cont) begin
          finish     = 1'b1;
          fin_status = (wanted == '0) ? dppm_pkg::ST_COMPLETE : dppm_pkg::ST_VALID;
          fin_wanted = wanted;
        end else if (!in_range) begin
          finish     = 1'b1;
          fin_status = dppm_pkg::ST_MORE;
        end else if ((code_cur > dppm_pkg::CODE_HASH) || (link == '0)) begin
          finish     = 1'b1;
          fin_status = dppm_pkg::ST_WRONG;
        end else begin
          advance = 1'b1;
          rd_en   = 1'b1;
        end
      end
      dppm_pkg::CMD_INSERT: begin
        if (full_r) begin
          finish     = 1'b1;
          fin_status = dppm_pkg::ST_FULL;
        end else if (in_range && (code_cur <= dppm_pkg::DIGIT_MAX)) begin
          if (link != '0) begin
            advance = 1'b1;
            rd_en   = 1'b1;
          end else if (nfree_r >= CW'(NODE_COUNT)) begin
            set_full   = 1'b1;
            finish     = 1'b1;
            fin_status = dppm_pkg::ST_FULL;
          end else begin
            advance   = 1'b1;
            alloc     = 1'b1;
            next_node = NW'(nfree_r);
            rd_addr   = NW'(nfree_r);
            rd_en     = 1'b1;
            wr_en     = 1'b1;
          end
        end else begin
          finish     = 1'b1;
          fin_status = dppm_pkg::ST_STORED;
          wr_en      = (idx_r != '0);
          wr_data    = {remain, 1'b1, rd_data_r[LW-1:0]};
        end
      end
      default: begin
        finish     = 1'b1;
        fin_status = dppm_pkg::ST_WRONG;
      end
    endcase
    // Commands gate the memory ports.
    if (!cmd.step) begin
      rd_en = 1'b0;
      wr_en = 1'b0;
    end
    if (cmd.load) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end
    if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Item and walk registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_tuser;
      codes_r <= in_tdata[dppm_pkg::CODES_W-1:0];
      dlen_r  <= in_tdata[dppm_pkg::CODES_W +: dppm_pkg::LEN_W];
      nlen_r  <= in_tdata[dppm_pkg::CODES_W+dppm_pkg::LEN_W +: dppm_pkg::LEN_W];
      idx_r   <= '0;
      node_r  <= '0;
    end else if (cmd.step && advance) begin
      idx_r  <= idx_r + 1'b1;
      node_r <= next_node;
    end
    if (cmd.step && finish) begin
      res_status_r <= fin_status;
      res_wanted_r <= fin_wanted;
    end else if (cmd.clr_end) begin
      res_status_r <= dppm_pkg::ST_STORED;
      res_wanted_r <= '0;
    end
  end

  // Allocator, full flag and clearing counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nfree_r    <= CW'(1);
      full_r     <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      if (cmd.clr_end) begin
        nfree_r    <= CW'(1);
        full_r     <= 1'b0;
        clr_addr_r <= '0;
      end else begin
        if (cmd.clr_step) begin
          clr_addr_r <= clr_addr_r + 1'b1;
        end
        if (cmd.step && alloc) begin
          nfree_r <= nfree_r + 1'b1;
        end
        if (cmd.step && set_full) begin
          full_r <= 1'b1;
        end
      end
    end
  end

  assign nodes_wide = {{dppm_pkg::NODES_W{1'b0}}, nfree_r};

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_wanted_r <= res_wanted_r;
      out_nodes_r  <= nodes_wide[dppm_pkg::NODES_W-1:0];
    end
  end

  assign sts.clear_req = (cmd_r == dppm_pkg::CMD_CLEAR);
  assign sts.finished  = finish;
  assign sts.clr_last  = (clr_addr_r == NW'(NODE_COUNT - 1));
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'd0, out_nodes_r, out_wanted_r};

endmodule

### rtl/core/dial_plan_prefix_matcher_top.sv
// ----------------------------------------------------------------------------
// dial_plan_prefix_matcher_top
// Digit trie of dial-plan prefixes with clear, insert and lookup commands.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Contents
//   in_      slave      tvalid / tready    tuser command, tdata codes+lengths
//   out_     master     tvalid / tready    tuser status, tdata wanted+nodes
//
// An insert or lookup occupies the block from acceptance to hand-off: the
// accepting cycle, whose edge also reads the root row, then walk steps of
// one trie row read each through the single read port of the row memory,
// one for each digit walked and a final one that decides the result, then
// the hand-off that moves the result into the output register.
// A clear and the reset each run a clearing pass over all NODE_COUNT rows,
// one row a cycle; no item is accepted during the pass.
// The next item is accepted while a result still waits in the output
// register; a stalled output holds the block in its hand-off cycle only.
//
module dial_plan_prefix_matcher_top #(
  parameter int NODE_COUNT    = dppm_pkg::NODE_COUNT_DEF,
  parameter int PREFIX_DIGITS = dppm_pkg::PREFIX_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // cmd
  input  logic [63:0] in_tdata,   // digit_codes[43:0], digit_length[51:44],
                                  // number_length[59:52], zero [63:60]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // status
  output logic [23:0] out_tdata   // digits_wanted[7:0], nodes_used[16:8],
                                  // zero [23:17]
);

  // The controller only sequences; every trie access lives in the datapath.
  dppm_pkg::dppm_cmd_t cmd;
  dppm_pkg::dppm_sts_t sts;

  dppm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath owns the row memory, the node allocator and the output
  // register, so that a finished result is held apart from the next item.
  dppm_datapath #(
    .NODE_COUNT    (NODE_COUNT),
    .PREFIX_DIGITS (PREFIX_DIGITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/core/dppm_checker.sv
// ----------------------------------------------------------------------------
// dppm_checker
// Port-level checks on the dial-plan prefix matcher, bound to the top level.
// ----------------------------------------------------------------------------
module dppm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [2:0]  out_tuser,
  input logic [23:0] out_tdata
);

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Reset starts the clearing pass, so no transaction is taken next cycle.
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready straight after reset");

  // One item at a time: an accepted transaction closes the input.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready in the cycle after an accepted transaction");

  // Digits wanted is only reported with a valid prefix match.
  a_wanted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != dppm_pkg::ST_VALID) |-> out_tdata[7:0] == 8'd0)
    else $error("digits wanted set outside a valid match");

  // A valid match with digits wanted never reports zero of them.
  a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == dppm_pkg::ST_VALID) |-> out_tdata[7:0] != 8'd0)
    else $error("valid match with no digits wanted");

endmodule

bind dial_plan_prefix_matcher_top dppm_checker u_dppm_checker (.*);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dial-plan prefix matcher. A short table of
// directed transactions exercises the corner cases of insert and lookup, and
// segments of random clears, inserts and lookups follow. Every transaction is
// predicted by a software trie kept in step with the block, or given by its
// directed row; results are compared field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0]  CMD_BAD      = 2'd3;
  localparam logic [3:0]  CODE_STAR    = 4'd10;
  localparam int          RANDOM_ITEMS = 1000;
  localparam int          LIMIT_CYCLES = 500000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          NODES        = dppm_pkg::NODE_COUNT_DEF;
  localparam int          LINKS        = dppm_pkg::LINKS_PER_NODE;
  localparam int          DIGITS       = dppm_pkg::PREFIX_DIGITS_DEF;
  localparam int          SLOTS        = dppm_pkg::CODE_SLOTS;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] wanted;
    logic [8:0] nodes;
  } dial_result_t;

  typedef struct {
    logic [1:0]   cmd;
    logic [43:0]  codes;
    logic [7:0]   dlen;
    logic [7:0]   nlen;
    bit           typed;
    dial_result_t res;
  } dial_row_t;

  typedef struct {
    logic [43:0] codes;
    int unsigned len;
  } prefix_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;   // cmd
  logic [63:0] in_tdata;   // digit_codes[43:0], digit_length[51:44],
                           // number_length[59:52], zero [63:60]
  logic        out_tvalid;
  logic        out_tready;
  logic [2:0]  out_tuser;  // status
  logic [23:0] out_tdata;  // digits_wanted[7:0], nodes_used[16:8]

  dial_plan_prefix_matcher_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  // Shadow trie that mirrors the contents of the block.
  logic [7:0] trie_links [0:NODES-1][0:LINKS-1];
  bit         trie_term  [0:NODES-1];
  logic [7:0] trie_rem   [0:NODES-1];
  logic [8:0] trie_next;
  bit         trie_full;

  dial_result_t pending_results[$];
  dial_row_t    directed_rows[$];
  prefix_t      known_prefixes[$];

  int  cycles;
  int  fails;
  int  received;
  bit  steady;
  int  hold_left;
  bit  held_once;

  // --------------------------------------------------------------------------
  // Shadow trie
  // --------------------------------------------------------------------------
  function automatic void trie_wipe();
    for (int n = 0; n < NODES; n++) begin
      for (int k = 0; k < LINKS; k++) begin
        trie_links[n][k] = 8'd0;
      end
      trie_term[n] = 1'b0;
      trie_rem[n]  = 8'd0;
    end
    trie_next = 9'd1;
    trie_full = 1'b0;
  endfunction

  // Adds a prefix; it stops at the first non-digit and leaves any nodes that
  // were linked before the table ran out of room.
  function automatic logic [2:0] trie_insert(input logic [43:0] codes,
                                             input int unsigned plen,
                                             input int unsigned total);
    int unsigned lim;
    int unsigned node;
    int unsigned n;
    int unsigned c;
    int unsigned nxt;
    lim  = (plen > DIGITS) ? DIGITS : plen;
    node = 0;
    n    = 0;
    if (trie_full) return dppm_pkg::ST_FULL;
    while (n < lim) begin
      c = codes[4*n +: 4];
      if (c > dppm_pkg::DIGIT_MAX) break;
      nxt = trie_links[node][c];
      if (nxt == 0) begin
        if (trie_next >= NODES) begin
          trie_full = 1'b1;
          return dppm_pkg::ST_FULL;
        end
        nxt = trie_next;
        trie_links[node][c] = 8'(nxt);
        trie_next++;
      end
      node = nxt;
      n++;
    end
    if (n != 0) begin
      trie_term[node] = 1'b1;
      trie_rem[node]  = (total > n) ? 8'(total - n) : 8'd0;
    end
    return dppm_pkg::ST_STORED;
  endfunction

  // Walks the dialled digits; at a terminal the next digit decides whether a
  // longer prefix is followed instead.
  function automatic logic [2:0] trie_lookup(input logic [43:0] codes,
                                             input int unsigned dlen,
                                             output logic [7:0] wanted);
    int unsigned lim;
    int unsigned node;
    int unsigned c;
    int unsigned cn;
    int unsigned left;
    lim    = (dlen > DIGITS) ? DIGITS : dlen;
    node   = 0;
    wanted = 8'd0;
    for (int unsigned i = 0; i < lim; i++) begin
      c = codes[4*i +: 4];
      if (c > dppm_pkg::CODE_HASH) return dppm_pkg::ST_WRONG;
      node = trie_links[node][c];
      if (node == 0) return dppm_pkg::ST_WRONG;
      if (trie_term[node]) begin
        if (i + 1 < dlen && i + 1 < SLOTS) begin
          cn = codes[4*(i+1) +: 4];
          if (cn <= dppm_pkg::CODE_HASH) begin
            if (trie_links[node][cn] != 0) continue;
          end
        end
        left   = dlen - (i + 1);
        wanted = (left >= trie_rem[node]) ? 8'd0 : 8'(trie_rem[node] - left);
        return (wanted == 0) ? dppm_pkg::ST_COMPLETE : dppm_pkg::ST_VALID;
      end
    end
    return dppm_pkg::ST_MORE;
  endfunction

  function automatic dial_result_t dial_predict(input logic [1:0] cmd,
                                                input logic [43:0] codes,
                                                input logic [7:0] dlen,
                                                input logic [7:0] nlen);
    dial_result_t r;
    logic [7:0]   w;
    w = 8'd0;
    case (cmd)
      dppm_pkg::CMD_CLEAR: begin
        trie_wipe();
        r.status = dppm_pkg::ST_STORED;
      end
      dppm_pkg::CMD_INSERT: r.status = trie_insert(codes, dlen, nlen);
      dppm_pkg::CMD_LOOKUP: r.status = trie_lookup(codes, dlen, w);
      default:              r.status = dppm_pkg::ST_WRONG;
    endcase
    r.wanted = w;
    r.nodes  = trie_next;
    return r;
  endfunction

  // Digit string to slot codes: '*' is star, '#' is hash, unused slots none.
  function automatic logic [43:0] dial(input string s);
    logic [43:0] v;
    v = '1;
    for (int k = 0; k < s.len() && k < SLOTS; k++) begin
      case (s[k])
        "*":     v[4*k +: 4] = CODE_STAR;
        "#":     v[4*k +: 4] = dppm_pkg::CODE_HASH;
        default: v[4*k +: 4] = 4'(s[k] - "0");
      endcase
    end
    return v;
  endfunction

  function automatic void row(input logic [1:0] cmd, input string digits,
                              input int dlen, input int nlen,
                              input bit typed = 1'b0,
                              input logic [2:0] st = dppm_pkg::ST_MORE,
                              input int w = 0, input int nodes = 0);
    dial_row_t d;
    d.cmd        = cmd;
    d.codes      = dial(digits);
    d.dlen       = 8'(dlen);
    d.nlen       = 8'(nlen);
    d.typed      = typed;
    d.res.status = st;
    d.res.wanted = 8'(w);
    d.res.nodes  = 9'(nodes);
    directed_rows.push_back(d);
  endfunction

  // --------------------------------------------------------------------------
  // Clock, cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender: offers one transaction and records its prediction on acceptance.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] cmd, input logic [43:0] codes,
                           input logic [7:0] dlen, input logic [7:0] nlen,
                           input bit typed, input dial_result_t typed_res);
    dial_result_t r;
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 20) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {4'd0, nlen, dlen, codes};
    do @(posedge clk); while (!in_tready);
    r = dial_predict(cmd, codes, dlen, nlen);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold-off so that the block
  // fills up and stalls its input while the sender keeps offering.
  // --------------------------------------------------------------------------
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (!held_once && received >= 200) begin
        held_once  = 1'b1;
        hold_left  = HOLD_CYCLES;
        out_tready = 1'b0;
      end else begin
        out_tready = steady || ($urandom_range(0, 99) >= 20);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker
  // --------------------------------------------------------------------------
  task automatic report(input string what, input int due_v, input int got_v);
    fails++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what,
             due_v, got_v);
  endtask

  dial_result_t due;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      received++;
      if (pending_results.size() == 0) begin
        report("unexpected transaction, status", -1, out_tuser);
      end else begin
        due = pending_results.pop_front();
        if (out_tuser != due.status)
          report("status", due.status, out_tuser);
        if (out_tdata[7:0] != due.wanted)
          report("digits_wanted", due.wanted, out_tdata[7:0]);
        if (out_tdata[16:8] != due.nodes)
          report("nodes_used", due.nodes, out_tdata[16:8]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [1:0]   cmd;
    logic [43:0]  codes;
    logic [7:0]   dlen;
    logic [7:0]   nlen;
    int unsigned  len;
    int unsigned  extra;
    int           top;
    int           ins_pct;
    int           seg_len;
    int           r;
    int           done;
    int           waited;
    prefix_t      p;
    dial_result_t none;

    in_tvalid = 1'b0;
    in_tuser  = dppm_pkg::CMD_CLEAR;
    in_tdata  = 64'd0;
    rst_n     = 1'b0;
    steady    = 1'b0;
    none      = '0;
    trie_wipe();

    // Lookups on an empty table, the empty prefix, then a short prefix and
    // its remaining-digit count.
    row(dppm_pkg::CMD_LOOKUP, "", 0, 0, 1'b1, dppm_pkg::ST_MORE, 0, 1);
    row(dppm_pkg::CMD_LOOKUP, "123", 3, 0, 1'b1, dppm_pkg::ST_WRONG, 0, 1);
    row(dppm_pkg::CMD_INSERT, "", 0, 9, 1'b1, dppm_pkg::ST_STORED, 0, 1);
    row(dppm_pkg::CMD_INSERT, "12", 2, 5, 1'b1, dppm_pkg::ST_STORED, 0, 3);
    row(dppm_pkg::CMD_LOOKUP, "12", 2, 0, 1'b1, dppm_pkg::ST_VALID, 3, 3);
    row(dppm_pkg::CMD_LOOKUP, "12345", 5, 0);
    // A longer prefix behind a terminal, with a count clamped to zero.
    row(dppm_pkg::CMD_INSERT, "1234", 4, 2);
    row(dppm_pkg::CMD_LOOKUP, "1234", 4, 0);
    row(dppm_pkg::CMD_LOOKUP, "123", 3, 0);
    row(dppm_pkg::CMD_LOOKUP, "12*", 3, 0);
    row(dppm_pkg::CMD_LOOKUP, "12#5", 4, 0);
    row(dppm_pkg::CMD_LOOKUP, "*1", 2, 0);
    row(dppm_pkg::CMD_LOOKUP, "", 1, 0);
    // Insert that ends at a non-digit, and the deepest prefix.
    row(dppm_pkg::CMD_INSERT, "5#77", 4, 8);
    row(dppm_pkg::CMD_INSERT, "99999999999", 255, 255);
    row(dppm_pkg::CMD_LOOKUP, "99999999999", 255, 0);
    row(dppm_pkg::CMD_LOOKUP, "9999999999", 10, 0);
    row(dppm_pkg::CMD_LOOKUP, "1299", 1, 0);
    row(dppm_pkg::CMD_INSERT, "12", 2, 0);
    row(dppm_pkg::CMD_LOOKUP, "12", 2, 0);
    row(CMD_BAD, "1", 1, 1);
    row(dppm_pkg::CMD_CLEAR, "", 0, 0, 1'b1, dppm_pkg::ST_STORED, 0, 1);
    row(dppm_pkg::CMD_LOOKUP, "12", 2, 0, 1'b1, dppm_pkg::ST_WRONG, 0, 1);
    row(dppm_pkg::CMD_INSERT, "0000000000", 10, 0);
    row(dppm_pkg::CMD_LOOKUP, "00000000000", 11, 0);

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].cmd, directed_rows[i].codes, directed_rows[i].dlen,
                directed_rows[i].nlen, directed_rows[i].typed, directed_rows[i].res);

    // Random segments. Each picks a digit alphabet and an insert share: a
    // small alphabet makes prefixes share nodes, a high share fills the table.
    done = 0;
    while (done < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        known_prefixes.delete();
        send_item(dppm_pkg::CMD_CLEAR, 44'(({$urandom, $urandom})),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, none);
        done++;
      end
      ins_pct = $urandom_range(10, 70);
      top     = $urandom_range(1, 9);
      seg_len = $urandom_range(20, 60);
      for (int j = 0; j < seg_len && done < RANDOM_ITEMS; j++) begin
        // A stretch in the middle runs with neither side idling.
        steady = (done >= 500 && done < 650);
        r      = $urandom_range(0, 99);
        codes  = 44'({$urandom, $urandom});
        if (r < 3) begin
          cmd  = 2'($urandom_range(0, 3));
          dlen = 8'($urandom_range(0, 255));
          nlen = 8'($urandom_range(0, 255));
        end else if (r < 3 + ins_pct) begin
          cmd = dppm_pkg::CMD_INSERT;
          len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, DIGITS);
          for (int k = 0; k < len; k++)
            codes[4*k +: 4] = 4'($urandom_range(0, top));
          if (len > 0 && $urandom_range(0, 9) == 0)
            codes[4*$urandom_range(0, len-1) +: 4] = 4'($urandom_range(CODE_STAR, 15));
          dlen = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'(len);
          nlen = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'(len + $urandom_range(0, 8));
          if (len > 0) begin
            p.codes = codes;
            p.len   = len;
            known_prefixes.push_back(p);
            if (known_prefixes.size() > 64) void'(known_prefixes.pop_front());
          end
        end else begin
          cmd = dppm_pkg::CMD_LOOKUP;
          // Mostly a known prefix extended by a few digits, else fresh digits.
          if (known_prefixes.size() > 0 && $urandom_range(0, 99) < 85) begin
            p     = known_prefixes[$urandom_range(0, known_prefixes.size() - 1)];
            codes = p.codes;
            len   = p.len;
            extra = $urandom_range(0, 6);
          end else begin
            len   = 0;
            extra = $urandom_range(1, SLOTS);
          end
          for (int k = len; k < len + extra && k < SLOTS; k++)
            codes[4*k +: 4] = ($urandom_range(0, 15) == 0)
                              ? 4'($urandom_range(CODE_STAR, dppm_pkg::CODE_HASH))
                              : 4'($urandom_range(0, top));
          r = $urandom_range(0, 99);
          if (r < 70)      dlen = 8'(len + extra);
          else if (r < 85) dlen = 8'($urandom_range(0, len + extra));
          else             dlen = 8'($urandom_range(0, 255));
          nlen = 8'($urandom_range(0, 255));
        end
        if (cmd == dppm_pkg::CMD_CLEAR) known_prefixes.delete();
        send_item(cmd, codes, dlen, nlen, 1'b0, none);
        done++;
      end
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    steady    = 1'b0;

    // Drain, then keep watching for anything the block should not send.
    while (pending_results.size() != 0) @(posedge clk);
    waited = 0;
    while (waited < 40) begin
      @(posedge clk);
      waited++;
    end

    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
